FILE: hdl/phdr_pkg.sv
package phdr_pkg;

  // Header layout and limits
  localparam int HEADER_BYTES = 42;
  localparam int MAX_PAYLOAD  = 1024;
  localparam int COUNT_W      = 11;
  localparam int LEN_W        = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
  localparam logic [7:0]         PROTO_VERSION = 8'd1;
  localparam logic [7:0]         KIND_LAST     = 8'd5;

  // Magic word 'J','R','B','K' in arrival order
  localparam logic [7:0] MAGIC [4] = '{8'h4A, 8'h52, 8'h42, 8'h4B};

  // Verdict codes, first failing check wins
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_MAGIC    = 3'd2,
    ST_VERSION  = 3'd3,
    ST_KIND     = 3'd4,
    ST_RESERVED = 3'd5,
    ST_OVERSIZE = 3'd6,
    ST_LENGTH   = 3'd7
  } phdr_status_t;

  // One result item
  typedef struct packed {
    logic               is_verdict;
    logic               last_of_run;
    logic [7:0]         payload_byte;
    phdr_status_t       status;
    logic [2:0]         packet_kind;
    logic [31:0]        sequence_number;
    logic [31:0]        ack_number;
    logic [63:0]        frame_number;
    logic [63:0]        timestamp;
    logic [31:0]        button_mask;
    logic signed [15:0] axis_horizontal;
    logic signed [15:0] axis_vertical;
  } phdr_result_t;

  // Result slots filled by one input byte
  typedef struct packed {
    logic slot0;
    logic slot1;
  } phdr_push_t;

endpackage

FILE: hdl/phdr_in_if.sv
interface phdr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

FILE: hdl/phdr_out_if.sv
interface phdr_out_if;
  logic               valid;
  logic               ready;
  logic               is_verdict;
  logic               last_of_run;
  logic [7:0]         payload_byte;
  logic [2:0]         status;
  logic [2:0]         packet_kind;
  logic [31:0]        sequence_number;
  logic [31:0]        ack_number;
  logic [63:0]        frame_number;
  logic [63:0]        timestamp;
  logic [31:0]        button_mask;
  logic signed [15:0] axis_horizontal;
  logic signed [15:0] axis_vertical;

  modport source (
    output valid, input ready,
    output is_verdict, output last_of_run, output payload_byte, output status,
    output packet_kind, output sequence_number, output ack_number,
    output frame_number, output timestamp, output button_mask,
    output axis_horizontal, output axis_vertical
  );
  modport sink (
    input valid, output ready,
    input is_verdict, input last_of_run, input payload_byte, input status,
    input packet_kind, input sequence_number, input ack_number,
    input frame_number, input timestamp, input button_mask,
    input axis_horizontal, input axis_vertical
  );
endinterface

FILE: hdl/phdr_parse.sv
module phdr_parse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_packet,
  output phdr_pkg::phdr_push_t  push,
  output phdr_pkg::phdr_result_t res0,
  output phdr_pkg::phdr_result_t res1
);
  import phdr_pkg::*;

  logic [COUNT_W-1:0] byte_index_r, byte_index_nxt;
  logic               magic_r, magic_nxt;
  logic [7:0]         version_r, version_nxt;
  logic [7:0]         kind_r, kind_nxt;
  logic [15:0]        reserved_r, reserved_nxt;
  logic [31:0]        sequence_r, sequence_nxt;
  logic [31:0]        ack_r, ack_nxt;
  logic [63:0]        frame_r, frame_nxt;
  logic [63:0]        timestamp_r, timestamp_nxt;
  logic [31:0]        buttons_r, buttons_nxt;
  logic [31:0]        axes_r, axes_nxt;
  logic [LEN_W-1:0]   length_r, length_nxt;

  logic               counting;
  logic               in_header;
  logic [COUNT_W-1:0] pay_idx;
  logic [LEN_W-1:0]   pay_limit;
  logic               payload_hit;
  phdr_status_t       verdict_st;
  phdr_result_t       pay_res;
  phdr_result_t       ver_res;

  // Capture header bytes and advance the saturating byte counter
  always_comb begin
    byte_index_nxt = byte_index_r;
    magic_nxt      = magic_r;
    version_nxt    = version_r;
    kind_nxt       = kind_r;
    reserved_nxt   = reserved_r;
    sequence_nxt   = sequence_r;
    ack_nxt        = ack_r;
    frame_nxt      = frame_r;
    timestamp_nxt  = timestamp_r;
    buttons_nxt    = buttons_r;
    axes_nxt       = axes_r;
    length_nxt     = length_r;

    counting  = (byte_index_r != COUNT_MAX);
    in_header = (byte_index_r < COUNT_W'(HEADER_BYTES));

    if (counting) begin
      byte_index_nxt = byte_index_r + 1'b1;
      case (byte_index_r) inside
        [11'd0:11'd3]: begin
          if (data_byte != MAGIC[byte_index_r[1:0]]) magic_nxt = 1'b0;
        end
        11'd4:          version_nxt = data_byte;
        11'd5:          kind_nxt = data_byte;
        [11'd6:11'd7]:   reserved_nxt[{byte_index_r[0], 3'b000} +: 8] = data_byte;
        [11'd8:11'd11]:  sequence_nxt[{byte_index_r[1:0], 3'b000} +: 8] = data_byte;
        [11'd12:11'd15]: ack_nxt[{byte_index_r[1:0], 3'b000} +: 8] = data_byte;
        [11'd16:11'd23]: frame_nxt[{byte_index_r[2:0], 3'b000} +: 8] = data_byte;
        [11'd24:11'd31]: timestamp_nxt[{byte_index_r[2:0], 3'b000} +: 8] = data_byte;
        [11'd32:11'd35]: buttons_nxt[{byte_index_r[1:0], 3'b000} +: 8] = data_byte;
        [11'd36:11'd39]: axes_nxt[{byte_index_r[1:0], 3'b000} +: 8] = data_byte;
        [11'd40:11'd41]: length_nxt[{byte_index_r[0], 3'b000} +: 8] = data_byte;
        default: ;
      endcase
    end
  end

  // Forward a byte while its payload index is below the capped length
  always_comb begin
    pay_idx     = byte_index_r - COUNT_W'(HEADER_BYTES);
    pay_limit   = (length_r > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : length_r;
    payload_hit = counting && !in_header
                  && ({{(LEN_W-COUNT_W){1'b0}}, pay_idx} < pay_limit);
  end

  // Check the header as it stands after this byte
  always_comb begin
    if (byte_index_nxt < COUNT_W'(HEADER_BYTES))        verdict_st = ST_SHORT;
    else if (!magic_nxt)                                verdict_st = ST_MAGIC;
    else if (version_nxt != PROTO_VERSION)              verdict_st = ST_VERSION;
    else if (kind_nxt > KIND_LAST)                      verdict_st = ST_KIND;
    else if (reserved_nxt != '0)                        verdict_st = ST_RESERVED;
    else if (length_nxt > LEN_W'(MAX_PAYLOAD))          verdict_st = ST_OVERSIZE;
    else if ({{(LEN_W+1-COUNT_W){1'b0}}, byte_index_nxt}
             != (17'(HEADER_BYTES) + {1'b0, length_nxt})) verdict_st = ST_LENGTH;
    else                                                verdict_st = ST_OK;
  end

  // Build payload and verdict items
  always_comb begin
    pay_res              = '0;
    pay_res.status       = ST_OK;
    pay_res.payload_byte = data_byte;
    pay_res.last_of_run  = !end_of_packet;

    ver_res             = '0;
    ver_res.is_verdict  = 1'b1;
    ver_res.last_of_run = 1'b1;
    ver_res.status      = verdict_st;
    if (verdict_st == ST_OK) begin
      ver_res.packet_kind     = kind_nxt[2:0];
      ver_res.sequence_number = sequence_nxt;
      ver_res.ack_number      = ack_nxt;
      ver_res.frame_number    = frame_nxt;
      ver_res.timestamp       = timestamp_nxt;
      ver_res.button_mask     = buttons_nxt;
      ver_res.axis_horizontal = axes_nxt[15:0];
      ver_res.axis_vertical   = axes_nxt[31:16];
    end
  end

  // Place results into queue slots in order
  always_comb begin
    push = '0;
    res0 = ver_res;
    res1 = ver_res;
    if (accept) begin
      if (payload_hit) begin
        res0       = pay_res;
        push.slot0 = 1'b1;
        push.slot1 = end_of_packet;
      end else begin
        push.slot0 = end_of_packet;
      end
    end
  end

  // Control state: clear on reset and after the last byte of a packet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      magic_r      <= 1'b1;
    end else if (accept) begin
      if (end_of_packet) begin
        byte_index_r <= '0;
        magic_r      <= 1'b1;
      end else begin
        byte_index_r <= byte_index_nxt;
        magic_r      <= magic_nxt;
      end
    end
  end

  // Header fields: every byte is rewritten before a passing verdict reads it
  always_ff @(posedge clk) begin
    if (accept) begin
      version_r   <= version_nxt;
      kind_r      <= kind_nxt;
      reserved_r  <= reserved_nxt;
      sequence_r  <= sequence_nxt;
      ack_r       <= ack_nxt;
      frame_r     <= frame_nxt;
      timestamp_r <= timestamp_nxt;
      buttons_r   <= buttons_nxt;
      axes_r      <= axes_nxt;
      length_r    <= length_nxt;
    end
  end

endmodule

FILE: hdl/phdr_queue.sv
module phdr_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  phdr_pkg::phdr_push_t   push,
  input  phdr_pkg::phdr_result_t res0,
  input  phdr_pkg::phdr_result_t res1,
  input  logic                   pop,
  output logic                   room,
  output logic                   head_valid,
  output phdr_pkg::phdr_result_t head
);
  import phdr_pkg::*;

  localparam int DEPTH = 3;

  phdr_result_t q_r [DEPTH];
  phdr_result_t q_nxt [DEPTH];
  phdr_result_t shifted [DEPTH];
  logic [1:0]   cnt_r, cnt_nxt;
  logic [1:0]   base;

  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_r[0];
  // Two free entries guarantee space for the largest burst of one byte
  assign room       = !cnt_r[1];

  // Shift out the head on a transfer, then append the new results
  always_comb begin
    base = cnt_r - {1'b0, pop};
    for (int i = 0; i < DEPTH; i++) begin
      shifted[i] = (pop && i < DEPTH - 1) ? q_r[(i < DEPTH - 1) ? i + 1 : i] : q_r[i];
      if (push.slot0 && base == 2'(i))
        q_nxt[i] = res0;
      else if (push.slot1 && (base + 2'd1) == 2'(i))
        q_nxt[i] = res1;
      else
        q_nxt[i] = shifted[i];
    end
    cnt_nxt = base + {1'b0, push.slot0} + {1'b0, push.slot1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

FILE: hdl/packet_header_parser_core.sv
// Byte-serial packet header parser. One packet byte is taken per cycle on in_chan while the
// output queue has room, the last one flagged by end_of_packet. The first 42 bytes form a
// little-endian header that is captured in place; later bytes are forwarded on out_chan as
// payload items while their payload index is below the declared length capped at 1024. The
// last byte also yields a verdict item with a status (short, magic, version, kind, reserved,
// oversize, length mismatch, first failure wins) and, when it passes, the header fields; it
// comes right after that byte's payload item, if any. Results are registered in the output
// queue before they reach out_chan. A last byte that also carries payload gives two results
// and holds in_chan.ready low while the three-entry output queue drains. The byte counter
// saturates at 2047; bytes beyond it are dropped.
module packet_header_parser_core (
  input  logic       clk,
  input  logic       rst_n,
  phdr_in_if.sink    in_chan,
  phdr_out_if.source out_chan
);
  import phdr_pkg::*;

  logic         accept;
  logic         room;
  logic         head_valid;
  logic         pop;
  phdr_push_t   push;
  phdr_result_t res0;
  phdr_result_t res1;
  phdr_result_t head;

  assign in_chan.ready = room;
  assign accept        = in_chan.valid && room;
  assign pop           = head_valid && out_chan.ready;

  // Header capture and result generation
  phdr_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_chan.data_byte),
    .end_of_packet (in_chan.end_of_packet),
    .push          (push),
    .res0          (res0),
    .res1          (res1)
  );

  // Output queue decouples result transfers from byte intake
  phdr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .res0       (res0),
    .res1       (res1),
    .pop        (pop),
    .room       (room),
    .head_valid (head_valid),
    .head       (head)
  );

  // Drive the result channel from the queue head
  assign out_chan.valid           = head_valid;
  assign out_chan.is_verdict      = head.is_verdict;
  assign out_chan.last_of_run     = head.last_of_run;
  assign out_chan.payload_byte    = head.payload_byte;
  assign out_chan.status          = head.status;
  assign out_chan.packet_kind     = head.packet_kind;
  assign out_chan.sequence_number = head.sequence_number;
  assign out_chan.ack_number      = head.ack_number;
  assign out_chan.frame_number    = head.frame_number;
  assign out_chan.timestamp       = head.timestamp;
  assign out_chan.button_mask     = head.button_mask;
  assign out_chan.axis_horizontal = head.axis_horizontal;
  assign out_chan.axis_vertical   = head.axis_vertical;

endmodule

FILE: sim/phdr_checker.sv
module phdr_checker
  import phdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  phdr_in_if          in_mon,
  phdr_out_if         out_mon,
  output int unsigned fail_count,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Parser state as seen from the byte stream
  logic [COUNT_W-1:0] rx_count;
  logic               magic_ok;
  logic [7:0]         version_seen;
  logic [7:0]         kind_seen;
  logic [15:0]        reserved_seen;
  logic [31:0]        seq_seen;
  logic [31:0]        ack_seen;
  logic [63:0]        frame_seen;
  logic [63:0]        stamp_seen;
  logic [31:0]        buttons_seen;
  logic [31:0]        axes_seen;
  logic [LEN_W-1:0]   length_seen;

  // Results the parser still owes, oldest first
  phdr_result_t owed_results[$];

  function automatic void clear_packet_state();
    rx_count      = '0;
    magic_ok      = 1'b1;
    version_seen  = '0;
    kind_seen     = '0;
    reserved_seen = '0;
    seq_seen      = '0;
    ack_seen      = '0;
    frame_seen    = '0;
    stamp_seen    = '0;
    buttons_seen  = '0;
    axes_seen     = '0;
    length_seen   = '0;
  endfunction

  // First failing check wins
  function automatic phdr_status_t header_status();
    if (int'(rx_count) < HEADER_BYTES) return ST_SHORT;
    if (!magic_ok) return ST_MAGIC;
    if (version_seen != PROTO_VERSION) return ST_VERSION;
    if (kind_seen > KIND_LAST) return ST_KIND;
    if (reserved_seen != '0) return ST_RESERVED;
    if (int'(length_seen) > MAX_PAYLOAD) return ST_OVERSIZE;
    if (int'(rx_count) != HEADER_BYTES + int'(length_seen)) return ST_LENGTH;
    return ST_OK;
  endfunction

  // Store one header byte at its little-endian place
  function automatic void capture_header_byte(input int pos, input logic [7:0] b);
    if (pos < 4) begin
      if (b != MAGIC[pos]) magic_ok = 1'b0;
    end else if (pos == 4) begin
      version_seen = b;
    end else if (pos == 5) begin
      kind_seen = b;
    end else if (pos < 8) begin
      reserved_seen[8*(pos-6) +: 8] = b;
    end else if (pos < 12) begin
      seq_seen[8*(pos-8) +: 8] = b;
    end else if (pos < 16) begin
      ack_seen[8*(pos-12) +: 8] = b;
    end else if (pos < 24) begin
      frame_seen[8*(pos-16) +: 8] = b;
    end else if (pos < 32) begin
      stamp_seen[8*(pos-24) +: 8] = b;
    end else if (pos < 36) begin
      buttons_seen[8*(pos-32) +: 8] = b;
    end else if (pos < 40) begin
      axes_seen[8*(pos-36) +: 8] = b;
    end else begin
      length_seen[8*(pos-40) +: 8] = b;
    end
  endfunction

  // Work out the results one accepted byte causes
  function automatic void parse_byte(input logic [7:0] b, input logic eop);
    phdr_result_t run [2];
    int n;
    int pos;
    int limit;
    int i;
    n = 0;
    pos = int'(rx_count);
    run[0] = '0;
    run[1] = '0;
    if (rx_count != COUNT_MAX) begin
      if (pos < HEADER_BYTES) begin
        capture_header_byte(pos, b);
      end else begin
        limit = (int'(length_seen) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(length_seen);
        if (pos - HEADER_BYTES < limit) begin
          run[n].payload_byte = b;
          n++;
        end
      end
      rx_count = rx_count + 1'b1;
    end
    if (eop) begin
      run[n].is_verdict = 1'b1;
      run[n].status = header_status();
      if (run[n].status == ST_OK) begin
        run[n].packet_kind     = kind_seen[2:0];
        run[n].sequence_number = seq_seen;
        run[n].ack_number      = ack_seen;
        run[n].frame_number    = frame_seen;
        run[n].timestamp       = stamp_seen;
        run[n].button_mask     = buttons_seen;
        run[n].axis_horizontal = axes_seen[15:0];
        run[n].axis_vertical   = axes_seen[31:16];
      end
      n++;
      clear_packet_state();
    end
    if (n > 0) run[n-1].last_of_run = 1'b1;
    for (i = 0; i < n; i++) owed_results.insert(owed_results.size(), run[i]);
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Predict on input transfers, compare on result transfers
  always @(posedge clk) begin : monitor
    phdr_result_t want;
    if (!rst_n) begin
      clear_packet_state();
      owed_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        parse_byte(in_mon.data_byte, in_mon.end_of_packet);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (owed_results.size() == 0) begin
          $error("result transfer with nothing owed");
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          check_field("is_verdict", 64'(want.is_verdict), 64'(out_mon.is_verdict));
          check_field("last_of_run", 64'(want.last_of_run), 64'(out_mon.last_of_run));
          check_field("payload_byte", 64'(want.payload_byte), 64'(out_mon.payload_byte));
          check_field("status", 64'(want.status), 64'(out_mon.status));
          check_field("packet_kind", 64'(want.packet_kind), 64'(out_mon.packet_kind));
          check_field("sequence_number", 64'(want.sequence_number),
                      64'(out_mon.sequence_number));
          check_field("ack_number", 64'(want.ack_number), 64'(out_mon.ack_number));
          check_field("frame_number", want.frame_number, out_mon.frame_number);
          check_field("timestamp", want.timestamp, out_mon.timestamp);
          check_field("button_mask", 64'(want.button_mask), 64'(out_mon.button_mask));
          check_field("axis_horizontal", 64'(want.axis_horizontal),
                      64'(out_mon.axis_horizontal));
          check_field("axis_vertical", 64'(want.axis_vertical),
                      64'(out_mon.axis_vertical));
        end
      end
    end
    pending = owed_results.size();
  end

endmodule

FILE: sim/tb_top.sv
module tb_top;
  import phdr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 650;
  localparam int HOLD_CYCLES  = 400;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count;
  int unsigned bytes_sent;
  bit          steady;
  bit          hold_request;

  // Header under construction
  logic [7:0]  hdr_magic [4];
  logic [7:0]  hdr_version;
  logic [7:0]  hdr_kind;
  logic [15:0] hdr_reserved;
  logic [15:0] hdr_length;
  logic [31:0] hdr_seq;
  logic [31:0] hdr_ack;
  logic [63:0] hdr_frame;
  logic [63:0] hdr_stamp;
  logic [31:0] hdr_buttons;
  logic [15:0] hdr_axis_h;
  logic [15:0] hdr_axis_v;
  logic [7:0]  packet_q[$];

  phdr_in_if  in_chan();
  phdr_out_if out_chan();

  packet_header_parser_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  phdr_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        out_chan.ready <= steady || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  function automatic void fill_header_random();
    int i;
    for (i = 0; i < 4; i++) hdr_magic[i] = MAGIC[i];
    hdr_version  = PROTO_VERSION;
    hdr_kind     = 8'($urandom_range(0, 5));
    hdr_reserved = '0;
    hdr_length   = '0;
    hdr_seq      = $urandom;
    hdr_ack      = $urandom;
    hdr_frame    = {$urandom, $urandom};
    hdr_stamp    = {$urandom, $urandom};
    hdr_buttons  = $urandom;
    hdr_axis_h   = 16'($urandom);
    hdr_axis_v   = 16'($urandom);
  endfunction

  function automatic void push_le(input logic [63:0] v, input int nbytes);
    int i;
    for (i = 0; i < nbytes; i++) packet_q.insert(packet_q.size(), v[8*i +: 8]);
  endfunction

  function automatic void push_header();
    int i;
    for (i = 0; i < 4; i++) packet_q.insert(packet_q.size(), hdr_magic[i]);
    push_le(64'(hdr_version), 1);
    push_le(64'(hdr_kind), 1);
    push_le(64'(hdr_reserved), 2);
    push_le(64'(hdr_seq), 4);
    push_le(64'(hdr_ack), 4);
    push_le(hdr_frame, 8);
    push_le(hdr_stamp, 8);
    push_le(64'(hdr_buttons), 4);
    push_le(64'(hdr_axis_h), 2);
    push_le(64'(hdr_axis_v), 2);
    push_le(64'(hdr_length), 2);
  endfunction

  function automatic void push_payload(input int n);
    int i;
    for (i = 0; i < n; i++) packet_q.insert(packet_q.size(), 8'($urandom));
  endfunction

  function automatic void truncate_packet(input int n);
    while (packet_q.size() > n) void'(packet_q.pop_back());
  endfunction

  // Offer one byte with random idle cycles ahead of it; return at its transfer
  task automatic offer_byte(input logic [7:0] b, input logic eop);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 21) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.data_byte     <= b;
    in_chan.end_of_packet <= eop;
    do @(posedge clk); while (!in_chan.ready);
    bytes_sent++;
  endtask

  task automatic send_packet();
    int i;
    for (i = 0; i < packet_q.size(); i++) offer_byte(packet_q[i], i == packet_q.size() - 1);
    packet_q.delete();
  endtask

  initial begin : stimulus
    int k;
    int i;
    int mode;
    int plen;
    int pick;
    int random_start;
    steady       = 1'b0;
    hold_request = 1'b0;
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.data_byte     = '0;
    in_chan.end_of_packet = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // All-zero fields, kind 0, no payload: header ends on the last byte
    fill_header_random();
    hdr_kind = 8'd0;
    hdr_seq = '0; hdr_ack = '0; hdr_frame = '0; hdr_stamp = '0;
    hdr_buttons = '0; hdr_axis_h = '0; hdr_axis_v = '0;
    push_header();
    send_packet();

    // All-ones fields, extreme axes, kind 5, three payload bytes
    fill_header_random();
    hdr_kind = KIND_LAST;
    hdr_seq = '1; hdr_ack = '1; hdr_frame = '1; hdr_stamp = '1; hdr_buttons = '1;
    hdr_axis_h = 16'h8000; hdr_axis_v = 16'h7fff; hdr_length = 16'd3;
    push_header();
    packet_q.insert(packet_q.size(), 8'h00);
    packet_q.insert(packet_q.size(), 8'hff);
    packet_q.insert(packet_q.size(), 8'ha5);
    send_packet();

    // Remaining kinds
    for (k = 1; k < 5; k++) begin
      fill_header_random();
      hdr_kind = 8'(k);
      hdr_length = 16'd1;
      push_header();
      push_payload(1);
      send_packet();
    end

    // Short packets: one byte, and a header missing its last byte
    packet_q.insert(packet_q.size(), 8'hff);
    send_packet();
    fill_header_random();
    push_header();
    truncate_packet(HEADER_BYTES - 1);
    send_packet();

    // Magic mismatch at each position
    for (k = 0; k < 4; k++) begin
      fill_header_random();
      hdr_magic[k] = hdr_magic[k] ^ 8'h20;
      push_header();
      send_packet();
    end

    // Bad version, bad kind, nonzero reserved word
    fill_header_random(); hdr_version = 8'h00; push_header(); send_packet();
    fill_header_random(); hdr_version = 8'hff; push_header(); send_packet();
    fill_header_random(); hdr_kind = 8'd6; push_header(); send_packet();
    fill_header_random(); hdr_kind = 8'hff; push_header(); send_packet();
    fill_header_random(); hdr_reserved = 16'h8001; push_header(); send_packet();

    // Oversize declared lengths, payload still forwarded
    fill_header_random(); hdr_length = 16'(MAX_PAYLOAD + 1);
    push_header(); push_payload(5); send_packet();
    fill_header_random(); hdr_length = 16'hffff;
    push_header(); push_payload(2); send_packet();

    // Largest allowed length is not oversize; short payload gives a mismatch
    fill_header_random(); hdr_length = 16'(MAX_PAYLOAD);
    push_header(); push_payload(3); send_packet();

    // Length mismatch both ways; extra bytes are not forwarded
    fill_header_random(); hdr_length = 16'd4; push_header(); push_payload(2); send_packet();
    fill_header_random(); hdr_length = 16'd2; push_header(); push_payload(6); send_packet();

    // Bad magic and bad version together, with payload
    fill_header_random();
    hdr_magic[0] = 8'h00; hdr_version = 8'h02; hdr_length = 16'd3;
    push_header(); push_payload(3); send_packet();

    // Random packets: mostly well formed, some corrupted, some noise
    random_start = bytes_sent;
    k = 0;
    while (bytes_sent < random_start + RANDOM_BYTES) begin
      steady = (k >= 6 && k < 10);
      fill_header_random();
      plen = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
      hdr_length = 16'(plen);
      mode = $urandom_range(0, 99);
      if (k == 4) begin
        // Long hold-off on the result side while a packet with payload is offered
        hold_request = 1'b1;
        hdr_length = 16'd60;
        push_header();
        push_payload(60);
      end else if (mode < 10) begin
        push_payload($urandom_range(1, 80));
      end else begin
        if (mode >= 65) begin
          if ($urandom_range(0, 3) == 0) begin
            pick = $urandom_range(0, 3);
            hdr_magic[pick] = hdr_magic[pick] ^ 8'($urandom_range(1, 255));
          end
          if ($urandom_range(0, 3) == 0)
            hdr_version = PROTO_VERSION ^ 8'($urandom_range(1, 255));
          if ($urandom_range(0, 3) == 0) hdr_kind = 8'($urandom_range(6, 255));
          if ($urandom_range(0, 3) == 0) hdr_reserved = 16'($urandom_range(1, 65535));
          if ($urandom_range(0, 3) == 0)
            hdr_length = 16'($urandom_range(MAX_PAYLOAD + 1, 65535));
          if ($urandom_range(0, 3) == 0) begin
            if (plen > 0 && $urandom_range(0, 1) == 1) plen = $urandom_range(0, plen - 1);
            else plen = plen + $urandom_range(1, 6);
          end
        end
        push_header();
        push_payload(plen);
        if (mode >= 65 && $urandom_range(0, 4) == 0)
          truncate_packet($urandom_range(1, HEADER_BYTES - 1));
      end
      send_packet();
      k++;
    end
    steady = 1'b0;

    // Drain and give the verdict
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
